// ===== design/lps_pkg.sv =====
`timescale 1ns / 1ps
package lps_pkg;

    localparam int DATA_W  = 32;
    localparam int TIX_W   = 18;
    localparam int BIT_W   = 5;
    localparam int ENT_OUT = 5;
    localparam logic [5:0] TICKET_BASE = 6'd41;
    localparam logic [2:0] ADDR_QUANTUM = 3'd0;

    typedef enum logic [2:0] {
        CMD_WRITE  = 3'd0,
        CMD_READY  = 3'd1,
        CMD_RESUME = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_YIELD  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        RS_IDLE    = 2'd0,
        RS_READY   = 2'd1,
        RS_RUNNING = 2'd2,
        RS_STOPPED = 2'd3
    } t_rs;

    typedef enum logic [1:0] {
        KIND_ALARM = 2'd0,
        KIND_STOP  = 2'd1,
        KIND_RUN   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_CRD, S_CWR, S_P1RD, S_P1WR, S_DIV, S_P2RD, S_P2WR, S_FRD, S_FWR
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [1:0]  rs;
        logic [5:0]  nice;
        logic [15:0] user;
        logic [15:0] kern;
        logic [15:0] wcnt;
        logic [31:0] alarm;
    } t_entry;

endpackage

// ===== design/lottery_process_scheduler.sv =====
`timescale 1ns / 1ps
// Sequencing: commands 0-2 to an in-table index read the entry, write it back and
//   return to idle; a stop or yield, after its own write-back, walks the table
//   (alarms, ticket sum), runs a bit-serial restoring remainder, walks again until
//   the winner or the last entry, then does a final RMW. A zero total skips the draw.
// Flow: one word at a time; next word accepted once the FSM is back in idle.
// Output stalls hold the FSM in the stop write-back, alarm and final write states.
// Reset: synchronous active low; clears FSM, entry-written flags, current/previous
//   entry, output valid flag, and sets quantum to 50. No clearing pass.
module lottery_process_scheduler
    import lps_pkg::*;
#(
    parameter int NUM_ENTRIES = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: index[4:0] valid_req[5] nice[11:6] user_time[27:12]
    //        kernel_time[43:28] alarm_deadline[75:44] tick[107:76], zero pad
    input  logic [111:0] i_s_tdata,
    // tuser: command[2:0]
    input  logic [2:0]   i_s_tuser,
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: entry[4:0] switched[5], zero pad
    output logic [7:0]   o_m_tdata,
    // tuser: kind[1:0]
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast,
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IW    = $clog2(NUM_ENTRIES);
    localparam int SUM_W = TIX_W + IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);

    // ---------------- register port ----------------
    logic [7:0] r_quantum;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_QUANTUM) ? {24'd0, r_quantum} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= 8'd50;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_QUANTUM) begin
            r_quantum <= pwdata[7:0];
        end
    end

    // ---------------- state ----------------
    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [IW-1:0] r_ptr, n_ptr, r_cur, n_cur, r_prev, n_prev;
    logic          r_valid_req, n_valid_req;
    logic [5:0]    r_nice, n_nice;
    logic [15:0]   r_user, n_user, r_kern, n_kern;
    logic [31:0]   r_alarm, n_alarm, r_tick, n_tick, r_dvd, n_dvd;
    logic [SUM_W-1:0] r_total, n_total, r_win, n_win, r_sum, n_sum;
    logic [SUM_W:0]   r_rem, n_rem;
    logic [BIT_W-1:0] r_bit, n_bit;

    // output register
    logic        r_ovalid;
    t_kind       r_okind;
    logic [ENT_OUT-1:0] r_oent;
    logic        r_osw, r_olast;
    logic        out_free;
    logic        emit, emit_sw, emit_last;
    t_kind       emit_kind;

    // table memory; entries never written read as zero
    t_entry mem [NUM_ENTRIES];
    t_entry r_rdata;
    logic   r_rinit;
    logic [NUM_ENTRIES-1:0] r_init;
    logic   we;
    t_entry wdata, eff;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_ptr] <= wdata;
        end
        r_rdata <= mem[r_ptr];
        r_rinit <= r_init[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (we) begin
            r_init[r_ptr] <= 1'b1;
        end
    end

    assign eff = r_rinit ? r_rdata : '0;

    // tickets of the entry just read
    logic [5:0]       nice_share;
    logic [TIX_W-1:0] tix;
    logic [SUM_W-1:0] tix_ext, sum_new;
    assign nice_share = (eff.nice < TICKET_BASE) ? (TICKET_BASE - eff.nice) : 6'd0;
    assign tix = TIX_W'(nice_share) + TIX_W'(eff.user) + TIX_W'(eff.kern)
               + TIX_W'(eff.wcnt);
    assign tix_ext = SUM_W'(tix);
    assign sum_new = r_sum + tix_ext;

    // remainder step
    logic [SUM_W:0] rem_sh;
    assign rem_sh = {r_rem[SUM_W-1:0], r_dvd[DATA_W-1]};

    // input field views
    logic [4:0]    f_idx;
    logic [IW+4:0] idx_ext;
    logic          in_table, accept;
    assign f_idx    = i_s_tdata[4:0];
    assign idx_ext  = {{IW{1'b0}}, f_idx};
    assign in_table = ({27'd0, f_idx} < 32'(NUM_ENTRIES));
    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_ovalid || i_m_tready;

    logic alarm_fire;
    assign alarm_fire = eff.valid && (eff.alarm != 32'd0) && (eff.alarm < r_tick);

    // next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_s_tuser))
                        CMD_WRITE, CMD_READY, CMD_RESUME: begin
                            if (in_table) begin
                                n_state = S_CRD;
                            end
                        end
                        CMD_STOP, CMD_YIELD: n_state = S_CRD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CRD: n_state = S_CWR;
            S_CWR: begin
                case (r_cmd)
                    CMD_STOP: begin
                        if (out_free) begin
                            n_state = S_P1RD;
                        end
                    end
                    CMD_YIELD: n_state = S_P1RD;
                    default: n_state = S_IDLE;
                endcase
            end
            S_P1RD: n_state = S_P1WR;
            S_P1WR: begin
                if (!alarm_fire || out_free) begin
                    if (r_ptr != LAST_IDX) begin
                        n_state = S_P1RD;
                    end else if (n_total != '0) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_FRD;
                    end
                end
            end
            S_DIV: begin
                if (r_bit == BIT_W'(DATA_W - 1)) begin
                    n_state = S_P2RD;
                end
            end
            S_P2RD: n_state = S_P2WR;
            S_P2WR: begin
                if (t_rs'(eff.rs) == RS_READY && sum_new > r_win) begin
                    n_state = S_FRD;
                end else if (r_ptr == LAST_IDX) begin
                    n_state = S_FRD;
                end else begin
                    n_state = S_P2RD;
                end
            end
            S_FRD: n_state = S_FWR;
            S_FWR: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd       = r_cmd;
        n_ptr       = r_ptr;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_valid_req = r_valid_req;
        n_nice      = r_nice;
        n_user      = r_user;
        n_kern      = r_kern;
        n_alarm     = r_alarm;
        n_tick      = r_tick;
        n_total     = r_total;
        n_win       = r_win;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_bit       = r_bit;
        we          = 1'b0;
        wdata       = eff;
        emit        = 1'b0;
        emit_kind   = KIND_RUN;
        emit_sw     = 1'b0;
        emit_last   = 1'b0;
        o_s_tready  = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd       = t_cmd'(i_s_tuser);
                    n_valid_req = i_s_tdata[5];
                    n_nice      = i_s_tdata[11:6];
                    n_user      = i_s_tdata[27:12];
                    n_kern      = i_s_tdata[43:28];
                    n_alarm     = i_s_tdata[75:44];
                    n_tick      = i_s_tdata[107:76];
                    case (t_cmd'(i_s_tuser))
                        CMD_STOP, CMD_YIELD: n_ptr = r_cur;
                        default: n_ptr = idx_ext[IW-1:0];
                    endcase
                end
            end
            S_CWR: begin
                case (r_cmd)
                    CMD_WRITE: begin
                        we          = 1'b1;
                        wdata.valid = r_valid_req;
                        wdata.nice  = r_nice;
                        wdata.user  = r_user;
                        wdata.kern  = r_kern;
                        wdata.alarm = r_alarm;
                    end
                    CMD_READY: begin
                        we         = 1'b1;
                        wdata.rs   = RS_READY;
                        wdata.wcnt = 16'd0;
                    end
                    CMD_RESUME: begin
                        if (t_rs'(eff.rs) == RS_STOPPED) begin
                            we         = 1'b1;
                            wdata.rs   = RS_READY;
                            wdata.wcnt = 16'd0;
                        end
                    end
                    CMD_STOP: begin
                        if (out_free) begin
                            we        = 1'b1;
                            wdata.rs  = RS_STOPPED;
                            emit      = 1'b1;
                            emit_kind = KIND_STOP;
                            n_prev    = r_cur;
                            n_ptr     = '0;
                            n_total   = '0;
                        end
                    end
                    CMD_YIELD: begin
                        if (t_rs'(eff.rs) == RS_RUNNING) begin
                            we         = 1'b1;
                            wdata.rs   = RS_READY;
                            wdata.wcnt = 16'd0;
                        end
                        n_prev  = r_cur;
                        n_ptr   = '0;
                        n_total = '0;
                    end
                    default: ;
                endcase
            end
            S_P1WR: begin
                if (!alarm_fire || out_free) begin
                    if (alarm_fire) begin
                        we          = 1'b1;
                        wdata.alarm = 32'd0;
                        emit        = 1'b1;
                        emit_kind   = KIND_ALARM;
                    end
                    if (eff.valid) begin
                        n_total = r_total + tix_ext;
                    end
                    if (r_ptr != LAST_IDX) begin
                        n_ptr = r_ptr + 1'b1;
                    end else begin
                        n_ptr = '0;
                        n_rem = '0;
                        n_dvd = r_tick;
                        n_bit = '0;
                    end
                end
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, r_total}) begin
                    n_rem = rem_sh - {1'b0, r_total};
                end else begin
                    n_rem = rem_sh;
                end
                n_dvd = {r_dvd[DATA_W-2:0], 1'b0};
                n_bit = r_bit + 1'b1;
                n_win = n_rem[SUM_W-1:0];
                n_sum = '0;
                n_ptr = '0;
            end
            S_P2WR: begin
                if (t_rs'(eff.rs) == RS_READY) begin
                    if (sum_new <= r_win) begin
                        n_sum = sum_new;
                        if (eff.wcnt != 16'hFFFF) begin
                            we         = 1'b1;
                            wdata.wcnt = eff.wcnt + 16'd1;
                        end
                        n_ptr = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
                    end
                end else begin
                    n_ptr = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
                end
            end
            S_FWR: begin
                if (out_free) begin
                    we         = 1'b1;
                    wdata.rs   = RS_RUNNING;
                    wdata.wcnt = {8'd0, r_quantum};
                    emit       = 1'b1;
                    emit_kind  = KIND_RUN;
                    emit_sw    = (r_ptr != r_prev);
                    emit_last  = 1'b1;
                    n_cur      = r_ptr;
                end
            end
            default: ;
        endcase
    end

    logic [IW+ENT_OUT-1:0] ptr_ext;
    assign ptr_ext = {{ENT_OUT{1'b0}}, r_ptr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_prev   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_prev  <= n_prev;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_ptr       <= n_ptr;
        r_valid_req <= n_valid_req;
        r_nice      <= n_nice;
        r_user      <= n_user;
        r_kern      <= n_kern;
        r_alarm     <= n_alarm;
        r_tick      <= n_tick;
        r_total     <= n_total;
        r_win       <= n_win;
        r_sum       <= n_sum;
        r_rem       <= n_rem;
        r_dvd       <= n_dvd;
        r_bit       <= n_bit;
        if (emit) begin
            r_okind <= emit_kind;
            r_oent  <= (emit_kind == KIND_STOP) ? ptr_ext[ENT_OUT-1:0] : ptr_ext[ENT_OUT-1:0];
            r_osw   <= emit_sw;
            r_olast <= emit_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_osw, r_oent};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

`ifndef ASSERT_OFF
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_total != '0)
        else $error("remainder started with zero total");

    a_last_is_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser == KIND_RUN)
        else $error("final word is not a run decision");

    a_sum_below_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_P2WR |-> r_sum <= r_win)
        else $error("running sum passed the draw without a winner");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("output register overwritten");
`endif

endmodule

// ===== tb/lps_checker.sv =====
`timescale 1ns / 1ps
module lps_checker
    import lps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         o_s_tready,
    input  logic [111:0] i_s_tdata,
    input  logic [2:0]   i_s_tuser,
    input  logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  logic [7:0]   o_m_tdata,
    input  logic [1:0]   o_m_tuser,
    input  logic         o_m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           o_err_count,
    output int           o_pending
);

    typedef struct packed {
        t_kind      kind;
        logic [4:0] ent;
        logic       switched;
        logic       last;
    } t_sched_word;

    t_sched_word sched_q[$];

    logic        tbl_valid [32];
    t_rs         tbl_rs    [32];
    logic [5:0]  tbl_nice  [32];
    logic [15:0] tbl_user  [32];
    logic [15:0] tbl_kern  [32];
    logic [15:0] tbl_wait  [32];
    logic [31:0] tbl_alarm [32];
    logic [4:0]  cur_ent, prev_ent;
    logic [7:0]  quantum_r;

    function automatic logic [31:0] ticket_count(int i);
        logic [31:0] share;
        share = (tbl_nice[i] < TICKET_BASE) ? 32'(TICKET_BASE - tbl_nice[i]) : 32'd0;
        return share + tbl_user[i] + tbl_kern[i] + tbl_wait[i];
    endfunction

    function automatic void push_word(t_kind k, logic [4:0] e, logic sw);
        t_sched_word w;
        w.kind = k;
        w.ent = e;
        w.switched = sw;
        w.last = 1'b0;
        sched_q.push_back(w);
    endfunction

    // lottery pass: alarms, ticket sum, draw, run decision
    function automatic void run_lottery(logic [31:0] tick);
        logic [31:0] total, win, acc;
        logic [4:0]  pick;
        total = 0;
        pick = 0;
        if (tbl_rs[cur_ent] == RS_RUNNING) begin
            tbl_rs[cur_ent] = RS_READY;
            tbl_wait[cur_ent] = 0;
        end
        prev_ent = cur_ent;
        for (int i = 0; i < 32; i++) begin
            if (!tbl_valid[i]) continue;
            if (tbl_alarm[i] != 0 && tbl_alarm[i] < tick) begin
                tbl_alarm[i] = 0;
                push_word(KIND_ALARM, 5'(i), 1'b0);
            end
            total += ticket_count(i);
        end
        if (total != 0) begin
            win = tick % total;
            acc = 0;
            for (int i = 0; i < 32; i++) begin
                if (tbl_rs[i] != RS_READY) continue;
                acc += ticket_count(i);
                if (acc > win) begin
                    pick = 5'(i);
                    break;
                end
                if (tbl_wait[i] != 16'hFFFF) tbl_wait[i]++;
            end
        end
        tbl_rs[pick] = RS_RUNNING;
        tbl_wait[pick] = 16'(quantum_r);
        cur_ent = pick;
        push_word(KIND_RUN, pick, pick != prev_ent);
    endfunction

    function automatic void apply_word(logic [2:0] cmd, logic [111:0] d);
        logic [4:0]  idx;
        logic [31:0] tick;
        int          n0;
        idx = d[4:0];
        tick = d[107:76];
        n0 = sched_q.size();
        case (cmd)
            CMD_WRITE: begin
                tbl_valid[idx] = d[5];
                tbl_nice[idx] = d[11:6];
                tbl_user[idx] = d[27:12];
                tbl_kern[idx] = d[43:28];
                tbl_alarm[idx] = d[75:44];
            end
            CMD_READY: begin
                tbl_rs[idx] = RS_READY;
                tbl_wait[idx] = 0;
            end
            CMD_RESUME: begin
                if (tbl_rs[idx] == RS_STOPPED) begin
                    tbl_rs[idx] = RS_READY;
                    tbl_wait[idx] = 0;
                end
            end
            CMD_STOP: begin
                tbl_rs[cur_ent] = RS_STOPPED;
                push_word(KIND_STOP, cur_ent, 1'b0);
                run_lottery(tick);
            end
            CMD_YIELD: run_lottery(tick);
            default: ;
        endcase
        if (sched_q.size() > n0) sched_q[$].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_sched_word exp_w;
        if (!i_rst_n) begin
            sched_q.delete();
            o_err_count <= 0;
            o_pending <= 0;
            for (int i = 0; i < 32; i++) begin
                tbl_valid[i] = 0;
                tbl_rs[i] = RS_IDLE;
                tbl_nice[i] = 0;
                tbl_user[i] = 0;
                tbl_kern[i] = 0;
                tbl_wait[i] = 0;
                tbl_alarm[i] = 0;
            end
            cur_ent = 0;
            prev_ent = 0;
            quantum_r = 8'd50;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (sched_q.size() == 0) begin
                    $error("unexpected result word: kind %0d entry %0d", o_m_tuser,
                           o_m_tdata[4:0]);
                    o_err_count <= o_err_count + 1;
                end else begin
                    exp_w = sched_q.pop_front();
                    if (o_m_tuser != exp_w.kind || o_m_tdata[4:0] != exp_w.ent ||
                        o_m_tdata[5] != exp_w.switched || o_m_tlast != exp_w.last)
                        o_err_count <= o_err_count + 1;
                    if (o_m_tuser != exp_w.kind)
                        $error("kind: expected %0d, got %0d", exp_w.kind, o_m_tuser);
                    if (o_m_tdata[4:0] != exp_w.ent)
                        $error("entry: expected %0d, got %0d", exp_w.ent, o_m_tdata[4:0]);
                    if (o_m_tdata[5] != exp_w.switched)
                        $error("switched: expected %0d, got %0d", exp_w.switched,
                               o_m_tdata[5]);
                    if (o_m_tlast != exp_w.last)
                        $error("last: expected %0d, got %0d", exp_w.last, o_m_tlast);
                end
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_QUANTUM)
                quantum_r = pwdata[7:0];
            if (i_s_tvalid && o_s_tready)
                apply_word(i_s_tuser, i_s_tdata);
            o_pending <= sched_q.size();
        end
    end

endmodule

// ===== tb/tb_lottery_process_scheduler.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the lottery scheduler. Command words go in on the
// slave stream, scheduling words (alarm, stop, run decision) come out on the
// master stream; lps_checker predicts and compares every result word.
module tb_lottery_process_scheduler;
    import lps_pkg::*;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    // tdata: index, valid_req, nice, user_time, kernel_time, alarm_deadline, tick
    logic [111:0] i_s_tdata = '0;
    // tuser: command
    logic [2:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    // tdata: entry, switched
    logic [7:0]   o_m_tdata;
    // tuser: kind
    logic [1:0]   o_m_tuser;
    logic         o_m_tlast;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int err_count, pending;
    bit written [32];      // entries whose fields are defined
    bit calm;              // stretch with no idling on either side
    logic [31:0] now_tick;

    always #5 i_clk = ~i_clk;

    lottery_process_scheduler #(.NUM_ENTRIES(32)) dut (.*);

    lps_checker u_checker (
        .i_clk, .i_rst_n, .i_s_tvalid, .o_s_tready, .i_s_tdata, .i_s_tuser,
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tuser, .o_m_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_err_count(err_count), .o_pending(pending)
    );

    // sink backpressure, about a third of cycles stalled
    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= 32);
    end

    // watchdog
    initial begin
        #5ms;
        $display("tb_lottery_process_scheduler: errors");
        $finish;
    end

    task automatic send_word(t_cmd cmd, logic [4:0] idx, logic v, logic [5:0] nice,
                             logic [15:0] usr, logic [15:0] krn, logic [31:0] alarm,
                             logic [31:0] tick);
        if (!calm && $urandom_range(99) < 32) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= {4'b0, tick, alarm, krn, usr, nice, v, idx};
        if (cmd == CMD_WRITE) written[idx] = 1'b1;
        // tready is stable mid-cycle; the word goes in at the next rising edge
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // wait out results, then the tail of any no-result command
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic set_quantum(logic [7:0] q);
        drain();
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_QUANTUM; pwdata <= 32'(q);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    task automatic random_word();
        int          r;
        logic [4:0]  idx;
        logic [31:0] alarm;
        logic [15:0] usr, krn;
        r = $urandom_range(99);
        idx = 5'($urandom_range(31));
        now_tick += $urandom_range(0, 400);
        if ($urandom_range(19) == 0) now_tick = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: alarm = 0;
            4:          alarm = $urandom;
            5:          alarm = 32'hFFFF_FFFF;
            default:    alarm = now_tick + $urandom_range(0, 3000);
        endcase
        usr = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
        krn = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
        if (r < 28)
            send_word(CMD_WRITE, idx, $urandom_range(9) != 0, 6'($urandom_range(63)),
                      usr, krn, alarm, $urandom);
        else if (r < 48) begin
            if (!written[idx]) idx = 0;
            send_word(CMD_READY, idx, 1'($urandom), 6'($urandom), 16'($urandom),
                      16'($urandom), $urandom, $urandom);
        end else if (r < 58) begin
            if (!written[idx]) idx = 0;
            send_word(CMD_RESUME, idx, 0, 0, 0, 0, 0, now_tick);
        end else if (r < 68)
            send_word(CMD_STOP, 5'($urandom), 0, 0, 0, 0, 0, now_tick);
        else if (r < 96)
            send_word(CMD_YIELD, 5'($urandom), 0, 0, 0, 0, 0, now_tick);
        else
            send_word(t_cmd'(3'($urandom_range(5, 7))), idx, 1, 0, 0, 0, 0, now_tick);
    endtask

    initial begin
        calm = 0;
        now_tick = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle entry written first so every later draw reads defined fields
        send_word(CMD_WRITE, 0, 1, 0, 0, 0, 0, 0);
        send_word(CMD_WRITE, 31, 1, 63, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_word(CMD_WRITE, 5, 1, 40, 3, 0, 1, 0);
        send_word(CMD_WRITE, 9, 1, 41, 0, 2, 0, 0);
        send_word(CMD_YIELD, 0, 0, 0, 0, 0, 0, 0);         // no ready entry: idle
        send_word(CMD_READY, 31, 0, 0, 0, 0, 0, 0);
        send_word(CMD_READY, 5, 0, 0, 0, 0, 0, 0);
        send_word(CMD_READY, 9, 0, 0, 0, 0, 0, 0);
        send_word(CMD_YIELD, 0, 0, 0, 0, 0, 0, 10);        // alarm of entry 5 fires
        send_word(CMD_STOP, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_word(CMD_RESUME, 9, 0, 0, 0, 0, 0, 0);        // not stopped: no effect
        send_word(CMD_RESUME, 0, 0, 0, 0, 0, 0, 0);
        send_word(t_cmd'(3'd5), 3, 1, 0, 0, 0, 0, 0);
        send_word(t_cmd'(3'd6), 3, 1, 0, 0, 0, 0, 0);
        send_word(t_cmd'(3'd7), 3, 1, 0, 0, 0, 0, 0);
        send_word(CMD_YIELD, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_word(CMD_STOP, 0, 0, 0, 0, 0, 0, 7);          // stop again, maybe idle
        send_word(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0);
        send_word(CMD_WRITE, 5, 0, 0, 0, 0, 0, 0);
        send_word(CMD_WRITE, 9, 0, 0, 0, 0, 0, 0);
        send_word(CMD_WRITE, 31, 0, 0, 0, 0, 0, 0);
        send_word(CMD_YIELD, 0, 0, 0, 0, 0, 0, 1234);      // zero total: idle, no draw
        send_word(CMD_WRITE, 0, 1, 20, 5, 5, 0, 0);

        // random phases at several quantum settings, extremes included
        set_quantum(8'd1);
        for (int n = 0; n < 110; n++) begin
            calm = (n >= 40 && n < 80);
            random_word();
        end
        calm = 0;
        set_quantum(8'd255);
        for (int n = 0; n < 110; n++) random_word();
        set_quantum(8'($urandom_range(2, 254)));
        for (int n = 0; n < 110; n++) random_word();

        drain();
        if (err_count == 0)
            $display("tb_lottery_process_scheduler: clean");
        else
            $display("tb_lottery_process_scheduler: errors");
        $finish;
    end

endmodule
